FILE: rtl/nat_address_checksum_rewrite_top_defines.svh
// ----------------------------------------------------------------------------
// NAT checksum rewrite assertion macros
// Shared property macros for the NAT address and checksum rewrite block.
// ----------------------------------------------------------------------------
`ifndef NAT_ADDRESS_CHECKSUM_REWRITE_TOP_DEFINES_SVH
`define NAT_ADDRESS_CHECKSUM_REWRITE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NATCR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NATCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/natcr_pkg.sv
// ----------------------------------------------------------------------------
// NAT checksum rewrite package
// Types, constants and one's complement helpers shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package natcr_pkg;

    localparam int QDEPTH = 2;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [3:0] WORD_FLAGS  = 4'd1;
    localparam logic [3:0] WORD_PROTO  = 4'd2;
    localparam logic [3:0] WORD_SOURCE = 4'd3;
    localparam logic [3:0] WORD_DEST   = 4'd4;
    localparam logic [3:0] WORD_SAT    = 4'd15;

    localparam logic [15:0] CSUM_ALL_ONES = 16'hFFFF;

    typedef enum logic [1:0] {
        L4_NONE,
        L4_TCP,
        L4_UDP
    } natcr_l4_class_t;

    typedef struct packed {
        logic [15:0]     header_sum;
        logic [31:0]     saved_source;
        logic [31:0]     saved_dest;
        logic [31:0]     new_address;
        logic [15:0]     l4_checksum;
        natcr_l4_class_t l4_class;
        logic            rewrite_dest;
        logic            l4_uninverted;
    } natcr_desc_t;

    typedef struct packed {
        logic        valid;
        natcr_desc_t desc;
    } natcr_slot_t;

    function automatic logic [16:0] halves(input logic [31:0] w);
        return {1'b0, w[15:0]} + {1'b0, w[31:16]};
    endfunction

    function automatic logic [15:0] fold20(input logic [19:0] s);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, s[15:0]} + {13'b0, s[19:16]};
        s2 = {1'b0, s1[15:0]} + {16'b0, s1[16]};
        return s2[15:0];
    endfunction

endpackage

FILE: rtl/natcr_queue.sv
// ----------------------------------------------------------------------------
// NAT checksum rewrite descriptor queue
// Short FIFO of packet descriptors between the header front end and the
// checksum back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module natcr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  natcr_pkg::natcr_slot_t push,
    input  logic                 pop,
    output natcr_pkg::natcr_slot_t head,
    output logic                 full
);
    import natcr_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    natcr_desc_t      entries [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(QDEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.desc  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push.desc;
        end
    end

endmodule

FILE: rtl/natcr_front.sv
// ----------------------------------------------------------------------------
// NAT checksum rewrite front end
// Accepts header words, keeps the running header sum and the original
// addresses, and classifies the packet into a descriptor on the last word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module natcr_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   hdr_valid,
    output logic                   hdr_stall,
    input  logic [31:0]            header_word,
    input  logic                   word_last,
    input  logic                   rewrite_dest,
    input  logic [31:0]            new_address,
    input  logic [15:0]            l4_checksum,
    input  logic                   l4_uninverted,
    input  logic                   queue_full,
    output natcr_pkg::natcr_slot_t push
);
    import natcr_pkg::*;

    logic [3:0]  word_index_reg;
    logic [3:0]  word_index_next;
    logic [15:0] running_sum_reg;
    logic [15:0] running_sum_next;
    logic [31:0] saved_source_reg;
    logic [31:0] saved_source_next;
    logic [31:0] saved_dest_reg;
    logic [31:0] saved_dest_next;
    logic [7:0]  protocol_reg;
    logic [7:0]  protocol_next;
    logic        frag_nonzero_reg;
    logic        frag_nonzero_next;
    logic        accept;

    assign hdr_stall = queue_full;
    assign accept    = hdr_valid && !hdr_stall;

    always_comb
    begin
        running_sum_next  = running_sum_reg;
        saved_source_next = saved_source_reg;
        saved_dest_next   = saved_dest_reg;
        protocol_next     = protocol_reg;
        frag_nonzero_next = frag_nonzero_reg;
        unique case (word_index_reg)
            WORD_FLAGS:
            begin
                frag_nonzero_next = (header_word[12:0] != 13'd0);
                running_sum_next  = fold20({4'b0, running_sum_reg}
                                           + {3'b0, halves(header_word)});
            end
            WORD_PROTO:
            begin
                protocol_next    = header_word[23:16];
                running_sum_next = fold20({4'b0, running_sum_reg}
                                          + {4'b0, header_word[31:16]});
            end
            WORD_SOURCE:
            begin
                saved_source_next = header_word;
            end
            WORD_DEST:
            begin
                saved_dest_next = header_word;
            end
            default:
            begin
                running_sum_next = fold20({4'b0, running_sum_reg}
                                          + {3'b0, halves(header_word)});
            end
        endcase
        word_index_next = (word_index_reg == WORD_SAT) ? word_index_reg
                                                       : word_index_reg + 4'd1;

        push.valid              = accept && word_last;
        push.desc.header_sum    = running_sum_next;
        push.desc.saved_source  = saved_source_next;
        push.desc.saved_dest    = saved_dest_next;
        push.desc.new_address   = new_address;
        push.desc.l4_checksum   = l4_checksum;
        push.desc.rewrite_dest  = rewrite_dest;
        push.desc.l4_uninverted = l4_uninverted;
        if (frag_nonzero_next)
        begin
            push.desc.l4_class = L4_NONE;
        end
        else if (protocol_next == PROTO_TCP)
        begin
            push.desc.l4_class = L4_TCP;
        end
        else if (protocol_next == PROTO_UDP)
        begin
            push.desc.l4_class = L4_UDP;
        end
        else
        begin
            push.desc.l4_class = L4_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_index_reg   <= '0;
            running_sum_reg  <= '0;
            saved_source_reg <= '0;
            saved_dest_reg   <= '0;
            protocol_reg     <= '0;
            frag_nonzero_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (word_last)
            begin
                word_index_reg   <= '0;
                running_sum_reg  <= '0;
                saved_source_reg <= '0;
                saved_dest_reg   <= '0;
                protocol_reg     <= '0;
                frag_nonzero_reg <= 1'b0;
            end
            else
            begin
                word_index_reg   <= word_index_next;
                running_sum_reg  <= running_sum_next;
                saved_source_reg <= saved_source_next;
                saved_dest_reg   <= saved_dest_next;
                protocol_reg     <= protocol_next;
                frag_nonzero_reg <= frag_nonzero_next;
            end
        end
    end

endmodule

FILE: rtl/natcr_back.sv
// ----------------------------------------------------------------------------
// NAT checksum rewrite back end
// Takes packet descriptors from the queue, forms the new addresses, the
// header checksum and the incrementally updated L4 checksum, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module natcr_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  natcr_pkg::natcr_slot_t head,
    output logic                   pop,
    output logic                   res_valid,
    input  logic                   res_stall,
    output logic [31:0]            new_source,
    output logic [31:0]            new_dest,
    output logic [15:0]            ip_checksum,
    output logic [15:0]            l4_checksum_out,
    output logic                   l4_updated
);
    import natcr_pkg::*;

    logic        res_valid_reg;
    logic [31:0] new_source_reg;
    logic [31:0] new_dest_reg;
    logic [15:0] ip_checksum_reg;
    logic [15:0] l4_checksum_reg;
    logic        l4_updated_reg;

    logic [31:0] ns;
    logic [31:0] nd;
    logic [19:0] ip_sum;
    logic [19:0] acc;
    logic [15:0] l4_direct;
    logic [15:0] l4_inverted;
    logic [15:0] l4_next;
    logic        upd_next;

    always_comb
    begin
        ns = head.desc.rewrite_dest ? head.desc.saved_source : head.desc.new_address;
        nd = head.desc.rewrite_dest ? head.desc.new_address : head.desc.saved_dest;
        ip_sum = {4'b0, head.desc.header_sum} + {3'b0, halves(ns)} + {3'b0, halves(nd)};
        acc = {3'b0, halves(ns)} + {3'b0, halves(nd)}
            + {3'b0, halves(~head.desc.saved_source)}
            + {3'b0, halves(~head.desc.saved_dest)};
        l4_direct   = fold20(acc + {4'b0, head.desc.l4_checksum});
        l4_inverted = ~fold20(acc + {4'b0, ~head.desc.l4_checksum});
        l4_next  = head.desc.l4_checksum;
        upd_next = 1'b0;
        unique case (head.desc.l4_class)
            L4_TCP:
            begin
                l4_next  = head.desc.l4_uninverted ? l4_direct : l4_inverted;
                upd_next = 1'b1;
            end
            L4_UDP:
            begin
                if (head.desc.l4_checksum != 16'd0)
                begin
                    l4_next  = (l4_inverted == 16'd0) ? CSUM_ALL_ONES : l4_inverted;
                    upd_next = 1'b1;
                end
            end
            default:
            begin
                l4_next  = head.desc.l4_checksum;
                upd_next = 1'b0;
            end
        endcase
    end

    assign pop = head.valid && (!res_valid_reg || !res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            new_source_reg  <= ns;
            new_dest_reg    <= nd;
            ip_checksum_reg <= ~fold20(ip_sum);
            l4_checksum_reg <= l4_next;
            l4_updated_reg  <= upd_next;
        end
    end

    assign res_valid       = res_valid_reg;
    assign new_source      = new_source_reg;
    assign new_dest        = new_dest_reg;
    assign ip_checksum     = ip_checksum_reg;
    assign l4_checksum_out = l4_checksum_reg;
    assign l4_updated      = l4_updated_reg;

endmodule

FILE: rtl/nat_address_checksum_rewrite_top.sv
// ----------------------------------------------------------------------------
// NAT address and checksum rewrite
// Rewrites the source or destination address of an IPv4 header, recomputes
// the header checksum and updates the TCP/UDP checksum incrementally.
//
// Channel  Handshake              Word
// hdr      hdr_valid, hdr_stall   one 32-bit header word with rewrite controls
// res      res_valid, res_stall   one rewrite result per packet (last word)
//
// One header word is taken per cycle while hdr_stall is low. The edge that
// accepts the last word of a packet writes its descriptor into the queue; the
// output register loads it when the back end pops it, once res_stall allows.
// Reset clears all packet state and the queue at once.
// hdr_stall is high only while the two-entry descriptor queue is full, which
// happens when res_stall holds results back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nat_address_checksum_rewrite_top_defines.svh"

module nat_address_checksum_rewrite_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hdr_valid,
    output logic        hdr_stall,
    input  logic [31:0] header_word,
    input  logic        word_last,
    input  logic        rewrite_dest,
    input  logic [31:0] new_address,
    input  logic [15:0] l4_checksum,
    input  logic        l4_uninverted,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] new_source,
    output logic [31:0] new_dest,
    output logic [15:0] ip_checksum,
    output logic [15:0] l4_checksum_out,
    output logic        l4_updated
);
    import natcr_pkg::*;

    natcr_slot_t push;
    natcr_slot_t head;
    logic        q_full;
    logic        pop;

    natcr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .hdr_valid     (hdr_valid),
        .hdr_stall     (hdr_stall),
        .header_word   (header_word),
        .word_last     (word_last),
        .rewrite_dest  (rewrite_dest),
        .new_address   (new_address),
        .l4_checksum   (l4_checksum),
        .l4_uninverted (l4_uninverted),
        .queue_full    (q_full),
        .push          (push)
    );

    natcr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (q_full)
    );

    natcr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .new_source      (new_source),
        .new_dest        (new_dest),
        .ip_checksum     (ip_checksum),
        .l4_checksum_out (l4_checksum_out),
        .l4_updated      (l4_updated)
    );

    `NATCR_ASSERT_SAME(a_no_push_when_full, push.valid, !q_full, "descriptor pushed into full queue")
    `NATCR_ASSERT_NEXT(a_last_word_queued, push.valid, head.valid, "last word left no descriptor")
    `NATCR_ASSERT_NEXT(a_res_drains, res_valid && !res_stall && !head.valid, !res_valid, "result repeated")

endmodule

FILE: tb/tb_nat_address_checksum_rewrite_top.sv
// ----------------------------------------------------------------------------
// NAT address and checksum rewrite testbench
// Sends IPv4 header words into the rewrite block and predicts, packet by
// packet, the rewritten addresses, the fresh header checksum and the
// incrementally updated TCP/UDP checksum. A scoreboard compares every result
// with its prediction, while input gaps, output stalls and a long output
// hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nat_address_checksum_rewrite_top;

    import natcr_pkg::*;

    localparam logic [7:0] PROTO_ICMP = 8'd1;

    typedef struct packed {
        logic [31:0] source;
        logic [31:0] dest;
        logic [15:0] ip_sum;
        logic [15:0] l4_sum;
        logic        l4_rewritten;
    } rewrite_result_t;

    class rewrite_scoreboard;
        logic [3:0]      word_pos;
        int unsigned     header_acc;
        logic [31:0]     orig_source;
        logic [31:0]     orig_dest;
        logic [7:0]      proto;
        bit              frag_nonzero;
        rewrite_result_t expected_q[$];
        int unsigned     words_seen;
        int unsigned     results_seen;
        int unsigned     l4_rewrites;
        int unsigned     error_count;

        function new();
            clear_packet();
            words_seen = 0;
            results_seen = 0;
            l4_rewrites = 0;
            error_count = 0;
        endfunction

        function void clear_packet();
            word_pos = 4'd0;
            header_acc = 0;
            orig_source = 32'd0;
            orig_dest = 32'd0;
            proto = 8'd0;
            frag_nonzero = 1'b0;
        endfunction

        function int unsigned fold_ones(int unsigned s);
            s = (s & 32'hFFFF) + (s >> 16);
            s = (s & 32'hFFFF) + (s >> 16);
            return s & 32'hFFFF;
        endfunction

        function int unsigned half_sum(logic [31:0] w);
            int unsigned lo;
            int unsigned hi;
            lo = 32'(w[15:0]);
            hi = 32'(w[31:16]);
            return lo + hi;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void flag(string msg);
            error_count++;
            if (error_count <= 10)
            begin
                $display("[%0t] ERROR: %s", $realtime, msg);
            end
        endfunction

        function void note_word(logic [31:0] w, bit last_word, bit dest_side,
                                logic [31:0] addr, logic [15:0] old_l4, bit complete);
            logic [31:0]     src_out;
            logic [31:0]     dst_out;
            int unsigned     acc;
            int unsigned     upper;
            logic [15:0]     inv_old;
            logic [15:0]     l4_out;
            bit              touched;
            rewrite_result_t want;
            words_seen++;
            case (word_pos)
                WORD_FLAGS:
                begin
                    frag_nonzero = (w[12:0] != 13'd0);
                    header_acc = fold_ones(header_acc + half_sum(w));
                end
                WORD_PROTO:
                begin
                    proto = w[23:16];
                    upper = 32'(w[31:16]);
                    header_acc = fold_ones(header_acc + upper);
                end
                WORD_SOURCE: orig_source = w;
                WORD_DEST:   orig_dest = w;
                default:     header_acc = fold_ones(header_acc + half_sum(w));
            endcase
            if (word_pos != WORD_SAT)
            begin
                word_pos++;
            end
            if (!last_word)
            begin
                return;
            end
            src_out = dest_side ? orig_source : addr;
            dst_out = dest_side ? addr : orig_dest;
            acc = half_sum(src_out) + half_sum(dst_out)
                + half_sum(~orig_source) + half_sum(~orig_dest);
            inv_old = ~old_l4;
            l4_out = old_l4;
            touched = 1'b0;
            if (!frag_nonzero)
            begin
                if (proto == PROTO_TCP)
                begin
                    if (complete)
                        l4_out = 16'(fold_ones(acc + 32'(old_l4)));
                    else
                        l4_out = 16'(~fold_ones(acc + 32'(inv_old)));
                    touched = 1'b1;
                end
                else if (proto == PROTO_UDP && old_l4 != 16'd0)
                begin
                    l4_out = 16'(~fold_ones(acc + 32'(inv_old)));
                    if (l4_out == 16'd0)
                        l4_out = CSUM_ALL_ONES;
                    touched = 1'b1;
                end
            end
            want.source = src_out;
            want.dest = dst_out;
            want.ip_sum = 16'(~fold_ones(header_acc + half_sum(src_out) + half_sum(dst_out)));
            want.l4_sum = l4_out;
            want.l4_rewritten = touched;
            if (touched)
                l4_rewrites++;
            expected_q.push_back(want);
            clear_packet();
        endfunction

        function void check_result(rewrite_result_t got);
            rewrite_result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                flag($sformatf("result with no packet pending: source %h dest %h",
                               got.source, got.dest));
                return;
            end
            want = expected_q.pop_front();
            if (got.source !== want.source)
                flag($sformatf("new_source expected %h, got %h", want.source, got.source));
            if (got.dest !== want.dest)
                flag($sformatf("new_dest expected %h, got %h", want.dest, got.dest));
            if (got.ip_sum !== want.ip_sum)
                flag($sformatf("ip_checksum expected %h, got %h", want.ip_sum, got.ip_sum));
            if (got.l4_sum !== want.l4_sum)
                flag($sformatf("l4_checksum_out expected %h, got %h",
                               want.l4_sum, got.l4_sum));
            if (got.l4_rewritten !== want.l4_rewritten)
                flag($sformatf("l4_updated expected %b, got %b",
                               want.l4_rewritten, got.l4_rewritten));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        hdr_valid;
    logic        hdr_stall;
    logic [31:0] header_word;
    logic        word_last;
    logic        rewrite_dest;
    logic [31:0] new_address;
    logic [15:0] l4_checksum;
    logic        l4_uninverted;
    logic        res_valid;
    logic        res_stall;
    logic [31:0] new_source;
    logic [31:0] new_dest;
    logic [15:0] ip_checksum;
    logic [15:0] l4_checksum_out;
    logic        l4_updated;

    rewrite_scoreboard sb;
    logic [31:0]       pkt_words[$];
    int                idle_pct;
    int                stall_pct;
    int                hold_len;
    int                words_sent;
    int                backpressure_cycles;

    nat_address_checksum_rewrite_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .hdr_valid       (hdr_valid),
        .hdr_stall       (hdr_stall),
        .header_word     (header_word),
        .word_last       (word_last),
        .rewrite_dest    (rewrite_dest),
        .new_address     (new_address),
        .l4_checksum     (l4_checksum),
        .l4_uninverted   (l4_uninverted),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .new_source      (new_source),
        .new_dest        (new_dest),
        .ip_checksum     (ip_checksum),
        .l4_checksum_out (l4_checksum_out),
        .l4_updated      (l4_updated)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Timeout waiting for results");
        $display("Test completed with failures");
        $finish;
    end

    // The output hold-off counts down here, one cycle per falling edge.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                res_stall <= 1'b1;
                hold_len = hold_len - 1;
            end
            else
            begin
                res_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : header_monitor
        if (rst_n && hdr_valid && !hdr_stall)
        begin
            sb.note_word(header_word, word_last, rewrite_dest, new_address,
                         l4_checksum, l4_uninverted);
        end
        if (rst_n && hdr_valid && hdr_stall)
        begin
            backpressure_cycles++;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        rewrite_result_t seen;
        if (rst_n && res_valid && !res_stall)
        begin
            seen.source = new_source;
            seen.dest = new_dest;
            seen.ip_sum = ip_checksum;
            seen.l4_sum = l4_checksum_out;
            seen.l4_rewritten = l4_updated;
            sb.check_result(seen);
        end
    end

    task automatic drive_word(logic [31:0] w, bit last_word, bit dest_side,
                              logic [31:0] addr, logic [15:0] old_l4, bit complete);
        @(negedge clk);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            hdr_valid <= 1'b0;
            @(negedge clk);
        end
        hdr_valid <= 1'b1;
        header_word <= w;
        word_last <= last_word;
        rewrite_dest <= dest_side;
        new_address <= addr;
        l4_checksum <= old_l4;
        l4_uninverted <= complete;
        @(posedge clk);
        while (hdr_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_packet(bit dest_side, logic [31:0] addr, logic [15:0] old_l4,
                               bit complete, bit scramble);
        int n;
        n = pkt_words.size();
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1 || !scramble)
                drive_word(pkt_words[i], i == n - 1, dest_side, addr, old_l4, complete);
            else
                drive_word(pkt_words[i], 1'b0, 1'($urandom), $urandom, 16'($urandom),
                           1'($urandom));
        end
        words_sent += n;
    endtask

    task automatic send_random_packet();
        int          len;
        logic [7:0]  proto;
        logic [12:0] offset;
        bit          dest_side;
        logic [31:0] addr;
        logic [15:0] old_l4;
        pkt_words.delete();
        if ($urandom_range(0, 99) < 85)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 18) : $urandom_range(5, 8);
            case ($urandom_range(0, 4))
                0, 1:    proto = PROTO_TCP;
                2, 3:    proto = PROTO_UDP;
                default: proto = 8'($urandom);
            endcase
            offset = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 8191)) : 13'd0;
            pkt_words.push_back({4'h4, 4'(len > 15 ? 15 : len), 8'($urandom), 16'($urandom)});
            pkt_words.push_back({16'($urandom), 3'($urandom), offset});
            pkt_words.push_back({8'($urandom), proto, 16'($urandom)});
            for (int i = 3; i < len; i++)
            begin
                pkt_words.push_back($urandom);
            end
        end
        else
        begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
            begin
                pkt_words.push_back($urandom);
            end
        end
        dest_side = 1'($urandom);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                if (dest_side)
                    addr = (len > 4) ? pkt_words[4] : 32'd0;
                else
                    addr = (len > 3) ? pkt_words[3] : 32'd0;
            end
            2:       addr = 32'd0;
            3:       addr = 32'hFFFF_FFFF;
            default: addr = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       old_l4 = 16'd0;
            1:       old_l4 = 16'hFFFF;
            default: old_l4 = 16'($urandom);
        endcase
        send_packet(dest_side, addr, old_l4, 1'($urandom), 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        hdr_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int phase_idle[4];
        int phase_stall[4];
        int phase_start;
        bit held;
        sb = new();
        idle_pct = 0;
        stall_pct = 0;
        hold_len = 0;
        words_sent = 0;
        backpressure_cycles = 0;
        hdr_valid = 1'b0;
        header_word = 32'd0;
        word_last = 1'b0;
        rewrite_dest = 1'b0;
        new_address = 32'd0;
        l4_checksum = 16'd0;
        l4_uninverted = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pkt_words = '{32'h0000_0000};
        send_packet(1'b0, 32'h0000_0000, 16'h0000, 1'b0, 1'b0);
        pkt_words = '{32'hFFFF_FFFF};
        send_packet(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
        pkt_words = '{32'h4500_0028, 32'h1c46_4000, {8'h40, PROTO_TCP, 16'hb1e6},
                      32'hc0a8_0001, 32'h0a00_0002};
        send_packet(1'b0, 32'hcb00_7105, 16'h1234, 1'b0, 1'b0);
        pkt_words = '{32'h4500_0034, 32'h8001_0000, {8'h3f, PROTO_TCP, 16'h0000},
                      32'hac10_0a0a, 32'hfffe_0001};
        send_packet(1'b1, 32'h0808_0808, 16'hfffe, 1'b1, 1'b0);
        pkt_words = '{32'h4500_001c, 32'h0000_4000, {8'h40, PROTO_UDP, 16'h0000},
                      32'h0a0a_0a0a, 32'h0a0a_0a0b};
        send_packet(1'b1, 32'h0a0a_0a0b, 16'hFFFF, 1'b0, 1'b0);
        pkt_words = '{32'h4500_001c, 32'h0000_0000, {8'h11, PROTO_UDP, 16'hffff}};
        send_packet(1'b0, 32'h7f00_0001, 16'h0000, 1'b0, 1'b0);
        pkt_words = '{32'h4500_0054, 32'hbeef_0000, {8'h80, PROTO_ICMP, 16'h1234}};
        send_packet(1'b1, 32'h0102_0304, 16'h5555, 1'b0, 1'b0);
        pkt_words = '{32'h4500_0400, 32'h1234_1fff, {8'h40, PROTO_TCP, 16'h0000}};
        send_packet(1'b0, 32'haaaa_5555, 16'h8001, 1'b0, 1'b0);
        wait_drained();

        phase_idle = '{0, 70, 0, 21};
        phase_stall = '{0, 0, 70, 21};
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            phase_start = words_sent;
            held = 1'b0;
            while (words_sent - phase_start < 370)
            begin
                if (p == 0 && !held && words_sent - phase_start > 120)
                begin
                    hold_len = 60;
                    held = 1'b1;
                end
                send_random_packet();
            end
            wait_drained();
        end
        idle_pct = 0;
        stall_pct = 0;

        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.flag($sformatf("%0d results never arrived", sb.pending()));
        end
        $display("Sent %0d header words; checked %0d results, %0d with a rewritten L4 checksum.",
                 sb.words_seen, sb.results_seen, sb.l4_rewrites);
        $display("Input was held back on %0d cycles; %0d errors found.",
                 backpressure_cycles, sb.error_count);
        if (sb.error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
